@@ design/rtq_pkg.sv @@
// rtq_pkg: shared types, codes and constants for the route table
// no dependencies
package rtq_pkg;

  localparam int ROUTE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(ROUTE_ENTRIES);
  localparam int CNT_W         = $clog2(ROUTE_ENTRIES + 1);

  localparam logic [16:0] REL_ONE   = 17'd65536;
  localparam int          DIV_STEPS = 30;
  localparam int          DCNT_W    = 5;
  localparam int          DSR_W     = 33;
  localparam int          SC_W      = 18;

  localparam logic [29:0]      HOP_NUM   = 30'd196608;
  localparam logic [29:0]      FRESH_NUM = 30'd786432000;
  localparam logic [DSR_W-1:0] FRESH_OFF = 33'd60000;
  localparam logic [SC_W-1:0]  FRESH_NEW = 18'd13107;

  typedef enum logic [1:0] {
    FN_UPDATE = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_SWEEP  = 2'd2,
    FN_PURGE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STS_ADDED    = 3'd0,
    STS_REPLACED = 3'd1,
    STS_KEPT     = 3'd2,
    STS_FOUND    = 3'd3,
    STS_NOTFOUND = 3'd4,
    STS_FULL     = 3'd5,
    STS_DONE     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_EVAL,
    S_DLOAD,
    S_DRUN,
    S_DECIDE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [31:0]        dest;
    logic [31:0]        nh;
    logic [7:0]         hops;
    logic [16:0]        rel;
    logic signed [7:0]  sig;
    logic [31:0]        bw;
    logic [7:0]         prio;
    logic [31:0]        last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // divisor of the hop term: 10 * (1 + hops)
  function automatic logic [DSR_W-1:0] hop_div(input logic [7:0] h);
    logic [DSR_W-1:0] t;
    t = DSR_W'(h) + DSR_W'(1);
    return (t << 3) + (t << 1);
  endfunction

endpackage

@@ design/rtq_ram.sv @@
// rtq_ram: generic single write, single read port ram with registered read
// no dependencies
module rtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/route_table_quality_replace.sv @@
// route_table_quality_replace: scored route table with lookup, aging and purge
// depends on rtq_pkg and rtq_ram
//
//  channel | ports               | handshake
//  --------+---------------------+---------------------------------
//  in      | in_func .. in_now_ms| in_valid / in_ready
//  out     | out_status .. count | out_valid / out_ready
//  cfg     | cfg_wdata           | cfg_we, no wait
//
// every request walks all ROUTE_ENTRIES entries through the one read port
// of the entry ram. an update that hits an existing route then adds three
// bit-serial divisions that score the old and the new route
// reset clears the valid flops and the state and sets the age limit to 300000 ms
// a request is taken only when the block is idle; a finished response waits
// in the output register and does not hold off the next request
module route_table_quality_replace (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [31:0]         in_destination,
  input  logic [31:0]         in_next_hop,
  input  logic [7:0]          in_hop_count,
  input  logic [16:0]         in_reliability,
  input  logic signed [7:0]   in_signal_strength,
  input  logic [31:0]         in_bandwidth,
  input  logic [7:0]          in_priority_req,
  input  logic [31:0]         in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [31:0]         out_route_next_hop,
  output logic [7:0]          out_route_hops,
  output logic [16:0]         out_route_reliability,
  output logic signed [7:0]   out_route_signal,
  output logic [31:0]         out_route_bandwidth,
  output logic [7:0]          out_route_priority,
  output logic [31:0]         out_route_last_used,
  output logic [5:0]          out_removed_count,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import rtq_pkg::*;

  state_t state_r, state_nxt;

  // latched request
  func_t       func_r;
  entry_t      req_r;

  logic [31:0] max_age_r;
  logic [ROUTE_ENTRIES-1:0] valid_r, valid_nxt;

  // walk pipeline: read issued at cnt_r, checked in the next cycle
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;

  // walk results
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  entry_t           hold_r, hold_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] rm_r, rm_nxt;
  status_t          sts_r, sts_nxt;

  // bit-serial divider
  logic [1:0]        sel_r, sel_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [29:0]       dvd_r, dvd_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [SC_W-1:0]   sc_old_r, sc_old_nxt;
  logic [SC_W-1:0]   sc_new_r, sc_new_nxt;
  logic [DSR_W:0]    rem_sh;
  logic              qbit;
  logic [29:0]       quot;

  // ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_ent;

  // output register
  logic             out_valid_r;
  logic             out_load;

  logic             kill;
  logic [31:0]      age_rd;
  logic [31:0]      age_hold;
  logic [16:0]      rel_sat;
  logic [15:0]      rm_wide;

  rtq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ROUTE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_ent   = entry_t'(ram_rdata);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign rel_sat  = (in_reliability > REL_ONE) ? REL_ONE : in_reliability;
  assign age_rd   = req_r.last - rd_ent.last;
  assign age_hold = req_r.last - hold_r.last;

  // one restoring division step
  assign rem_sh = {rem_r, dvd_r[29]};
  assign qbit   = (rem_sh >= {1'b0, dsr_r});
  assign quot   = {dvd_r[28:0], qbit};

  // sweep kills stale entries, purge kills entries through the given node
  always_comb begin
    if (func_r == FN_SWEEP) begin
      kill = age_rd > max_age_r;
    end else begin
      kill = rd_ent.nh == req_r.nh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      max_age_r   <= 32'd300000;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      chk_v_r <= chk_v_nxt;
      if (cfg_we) begin
        max_age_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r       <= func_t'(in_func);
      req_r.dest   <= in_destination;
      req_r.nh     <= in_next_hop;
      req_r.hops   <= in_hop_count;
      req_r.rel    <= rel_sat;
      req_r.sig    <= in_signal_strength;
      req_r.bw     <= in_bandwidth;
      req_r.prio   <= in_priority_req;
      req_r.last   <= in_now_ms;
    end
    cnt_r      <= cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hold_r     <= hold_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    rm_r       <= rm_nxt;
    sts_r      <= sts_nxt;
    sel_r      <= sel_nxt;
    dcnt_r     <= dcnt_nxt;
    dvd_r      <= dvd_nxt;
    dsr_r      <= dsr_nxt;
    rem_r      <= rem_nxt;
    sc_old_r   <= sc_old_nxt;
    sc_new_r   <= sc_new_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    chk_v_nxt    = 1'b0;
    chk_idx_nxt  = cnt_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hold_nxt     = hold_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    rm_nxt       = rm_r;
    sts_nxt      = sts_r;
    sel_nxt      = sel_r;
    dcnt_nxt     = dcnt_r;
    dvd_nxt      = dvd_r;
    dsr_nxt      = dsr_r;
    rem_nxt      = rem_r;
    sc_old_nxt   = sc_old_r;
    sc_new_nxt   = sc_new_r;
    ram_we       = 1'b0;
    ram_waddr    = hit_idx_r;
    ram_wdata    = req_r;
    ram_raddr    = cnt_r;
    out_load     = 1'b0;

    // check the entry read in the previous cycle
    if (chk_v_r) begin
      if (valid_r[chk_idx_r]) begin
        if ((func_r == FN_UPDATE || func_r == FN_LOOKUP) && !hit_r &&
            rd_ent.dest == req_r.dest) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = chk_idx_r;
          hold_nxt    = rd_ent;
        end
        if ((func_r == FN_SWEEP || func_r == FN_PURGE) && kill) begin
          valid_nxt[chk_idx_r] = 1'b0;
          rm_nxt               = rm_r + CNT_W'(1);
        end
      end else if (!free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = chk_idx_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          rm_nxt    = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        chk_v_nxt = 1'b1;
        if (cnt_r == IDX_W'(ROUTE_ENTRIES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_RESP;
        case (func_r)
          FN_UPDATE: begin
            if (hit_r) begin
              sel_nxt    = 2'd0;
              sc_old_nxt = SC_W'(hold_r.rel >> 1);
              sc_new_nxt = SC_W'(req_r.rel >> 1) + FRESH_NEW;
              state_nxt  = S_DLOAD;
            end else if (free_r) begin
              ram_we               = 1'b1;
              ram_waddr            = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              sts_nxt              = STS_ADDED;
            end else begin
              sts_nxt = STS_FULL;
            end
          end
          FN_LOOKUP: begin
            if (hit_r) begin
              ram_we         = 1'b1;
              ram_wdata      = hold_r;
              ram_wdata.last = req_r.last;
              hold_nxt.last  = req_r.last;
              sts_nxt        = STS_FOUND;
            end else begin
              sts_nxt = STS_NOTFOUND;
            end
          end
          default: begin
            sts_nxt = STS_DONE;
          end
        endcase
      end
      S_DLOAD: begin
        rem_nxt  = '0;
        dcnt_nxt = '0;
        case (sel_r)
          2'd0: begin
            dvd_nxt = HOP_NUM;
            dsr_nxt = hop_div(hold_r.hops);
          end
          2'd1: begin
            dvd_nxt = FRESH_NUM;
            dsr_nxt = DSR_W'(age_hold) + FRESH_OFF;
          end
          default: begin
            dvd_nxt = HOP_NUM;
            dsr_nxt = hop_div(req_r.hops);
          end
        endcase
        state_nxt = S_DRUN;
      end
      S_DRUN: begin
        rem_nxt  = qbit ? DSR_W'(rem_sh - {1'b0, dsr_r}) : DSR_W'(rem_sh);
        dvd_nxt  = quot;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          if (sel_r == 2'd2) begin
            sc_new_nxt = sc_new_r + SC_W'(quot);
            state_nxt  = S_DECIDE;
          end else begin
            sc_old_nxt = sc_old_r + SC_W'(quot);
            sel_nxt    = sel_r + 2'd1;
            state_nxt  = S_DLOAD;
          end
        end
      end
      S_DECIDE: begin
        if (sc_new_r > sc_old_r) begin
          ram_we  = 1'b1;
          sts_nxt = STS_REPLACED;
        end else begin
          sts_nxt = STS_KEPT;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rm_wide = 16'(rm_r);

  // response payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= sts_r;
      if (sts_r == STS_FOUND) begin
        out_route_next_hop    <= hold_r.nh;
        out_route_hops        <= hold_r.hops;
        out_route_reliability <= hold_r.rel;
        out_route_signal      <= hold_r.sig;
        out_route_bandwidth   <= hold_r.bw;
        out_route_priority    <= hold_r.prio;
        out_route_last_used   <= hold_r.last;
      end else begin
        out_route_next_hop    <= '0;
        out_route_hops        <= '0;
        out_route_reliability <= '0;
        out_route_signal      <= '0;
        out_route_bandwidth   <= '0;
        out_route_priority    <= '0;
        out_route_last_used   <= '0;
      end
      if (sts_r == STS_DONE) begin
        out_removed_count <= (rm_wide > 16'd63) ? 6'd63 : rm_wide[5:0];
      end else begin
        out_removed_count <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // ram writes happen only once the walk is over
  a_wr_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EVAL || state_r == S_DECIDE))
    else $error("entry write during walk or idle");

  // a response is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load)
    else $error("response overwritten");

  // removal count only on sweep or purge responses
  a_rm_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status != STS_DONE) |-> (out_removed_count == 6'd0))
    else $error("removal count on non-sweep response");
`endif

endmodule

@@ tb/route_table_quality_replace_checker.sv @@
// route table checker: watches the request and response channels, predicts each
// response from its own copy of the table and compares field by field
// depends on rtq_pkg
module route_table_quality_replace_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_destination,
  input  logic [31:0]        in_next_hop,
  input  logic [7:0]         in_hop_count,
  input  logic [16:0]        in_reliability,
  input  logic signed [7:0]  in_signal_strength,
  input  logic [31:0]        in_bandwidth,
  input  logic [7:0]         in_priority_req,
  input  logic [31:0]        in_now_ms,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_status,
  input  logic [31:0]        out_route_next_hop,
  input  logic [7:0]         out_route_hops,
  input  logic [16:0]        out_route_reliability,
  input  logic signed [7:0]  out_route_signal,
  input  logic [31:0]        out_route_bandwidth,
  input  logic [7:0]         out_route_priority,
  input  logic [31:0]        out_route_last_used,
  input  logic [5:0]         out_removed_count,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 replies_seen,
  output int                 hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtq_pkg::*;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        nh;
    logic [7:0]         hops;
    logic [16:0]        rel;
    logic signed [7:0]  sig;
    logic [31:0]        bw;
    logic [7:0]         prio;
    logic [31:0]        last;
    logic [5:0]         removed;
  } reply_t;

  logic        tbl_valid [ROUTE_ENTRIES];
  entry_t      tbl [ROUTE_ENTRIES];
  logic [31:0] age_limit;
  reply_t      awaited_replies[$];

  function automatic logic [63:0] route_score(logic [7:0] h, logic [16:0] r,
                                              logic [31:0] age);
    logic [63:0] hop_t, rel_t, fresh_t;
    hop_t   = 64'd196608 / (64'd10 * (64'd1 + h));
    rel_t   = {47'd0, r} >> 1;
    fresh_t = 64'd786432000 / (64'd60000 + age);
    return hop_t + rel_t + fresh_t;
  endfunction

  function automatic int find_route(logic [31:0] d);
    for (int i = 0; i < ROUTE_ENTRIES; i++)
      if (tbl_valid[i] && tbl[i].dest == d) return i;
    return -1;
  endfunction

  task automatic apply_request();
    reply_t     rp;
    logic [16:0] rel;
    entry_t     e;
    int         idx;
    int         cnt;
    logic       kill;
    rp  = '0;
    rel = (in_reliability > REL_ONE) ? REL_ONE : in_reliability;
    e   = '{in_destination, in_next_hop, in_hop_count, rel, in_signal_strength,
            in_bandwidth, in_priority_req, in_now_ms};
    cnt = 0;
    case (func_t'(in_func))
      FN_UPDATE: begin
        idx = find_route(in_destination);
        if (idx >= 0) begin
          if (route_score(in_hop_count, rel, 32'd0) >
              route_score(tbl[idx].hops, tbl[idx].rel, in_now_ms - tbl[idx].last)) begin
            tbl[idx] = e;
            rp.status = STS_REPLACED;
          end else
            rp.status = STS_KEPT;
        end else begin
          idx = -1;
          for (int i = 0; i < ROUTE_ENTRIES; i++)
            if (!tbl_valid[i] && idx < 0) idx = i;
          if (idx >= 0) begin
            tbl[idx] = e;
            tbl_valid[idx] = 1'b1;
            rp.status = STS_ADDED;
          end else
            rp.status = STS_FULL;
        end
      end
      FN_LOOKUP: begin
        idx = find_route(in_destination);
        if (idx >= 0) begin
          tbl[idx].last = in_now_ms;
          rp = '{STS_FOUND, tbl[idx].nh, tbl[idx].hops, tbl[idx].rel, tbl[idx].sig,
                 tbl[idx].bw, tbl[idx].prio, tbl[idx].last, 6'd0};
        end else
          rp.status = STS_NOTFOUND;
      end
      default: begin
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
          if (func_t'(in_func) == FN_SWEEP)
            kill = (in_now_ms - tbl[i].last) > age_limit;
          else
            kill = tbl[i].nh == in_next_hop;
          if (tbl_valid[i] && kill) begin
            tbl_valid[i] = 1'b0;
            cnt++;
          end
        end
        rp.status  = STS_DONE;
        rp.removed = (cnt > 63) ? 6'd63 : 6'(cnt);
      end
    endcase
    awaited_replies = {awaited_replies, rp};
  endtask

  task automatic compare_reply();
    reply_t x;
    if (awaited_replies.size() == 0) begin
      $error("response with nothing outstanding, status %0d", out_status);
      fail_count++;
      return;
    end
    x = awaited_replies.pop_front();
    if (out_status != x.status) begin
      $error("status expected %0d actual %0d", x.status, out_status); fail_count++; end
    if (out_route_next_hop != x.nh) begin
      $error("route_next_hop expected %0h actual %0h", x.nh, out_route_next_hop);
      fail_count++; end
    if (out_route_hops != x.hops) begin
      $error("route_hops expected %0d actual %0d", x.hops, out_route_hops); fail_count++; end
    if (out_route_reliability != x.rel) begin
      $error("route_reliability expected %0d actual %0d", x.rel, out_route_reliability);
      fail_count++; end
    if (out_route_signal != x.sig) begin
      $error("route_signal expected %0d actual %0d", x.sig, out_route_signal); fail_count++; end
    if (out_route_bandwidth != x.bw) begin
      $error("route_bandwidth expected %0h actual %0h", x.bw, out_route_bandwidth);
      fail_count++; end
    if (out_route_priority != x.prio) begin
      $error("route_priority expected %0d actual %0d", x.prio, out_route_priority);
      fail_count++; end
    if (out_route_last_used != x.last) begin
      $error("route_last_used expected %0h actual %0h", x.last, out_route_last_used);
      fail_count++; end
    if (out_removed_count != x.removed) begin
      $error("removed_count expected %0d actual %0d", x.removed, out_removed_count);
      fail_count++; end
    if (x.status == STS_FOUND) hits_seen++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    replies_seen = 0;
    hits_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      age_limit = 32'd300000;
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl[i] = '0;
      end
      awaited_replies.delete();
    end else begin
      if (cfg_we) age_limit = cfg_wdata;
      // response first: a request taken in the same cycle queues behind it
      if (out_valid && out_ready) begin
        compare_reply();
        replies_seen++;
      end
      if (in_valid && in_ready) apply_request();
    end
    pending = awaited_replies.size();
  end
endmodule

@@ tb/route_table_quality_replace_test.sv @@
// route table regression top: clock, reset, request stimulus, response stalls
// and the verdict; depends on rtq_pkg, the block and the checker
module route_table_quality_replace_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rtq_pkg::*;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int IDLE_LIMIT      = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [31:0]        in_destination;
  logic [31:0]        in_next_hop;
  logic [7:0]         in_hop_count;
  logic [16:0]        in_reliability;
  logic signed [7:0]  in_signal_strength;
  logic [31:0]        in_bandwidth;
  logic [7:0]         in_priority_req;
  logic [31:0]        in_now_ms;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic [31:0]        out_route_next_hop;
  logic [7:0]         out_route_hops;
  logic [16:0]        out_route_reliability;
  logic signed [7:0]  out_route_signal;
  logic [31:0]        out_route_bandwidth;
  logic [7:0]         out_route_priority;
  logic [31:0]        out_route_last_used;
  logic [5:0]         out_removed_count;
  logic               cfg_we;
  logic [31:0]        cfg_wdata;

  int fail_count, pending, replies_seen, hits_seen;
  int idle_cycles;
  int sweeps_sent;
  int stall_left;      // remaining cycles of a receiver stall burst
  bit quiet_phase;     // last part of the run: no idling on either side
  bit long_hold;       // receiver holds off for a long stretch
  bit stim_done;
  logic [31:0] clock_ms;   // running time for well-formed traffic

  // small pool of destinations and next hops so updates hit existing routes
  logic [31:0] dest_pool [16];
  logic [31:0] hop_pool [6];

  route_table_quality_replace DUT (.*);

  route_table_quality_replace_checker checker_inst (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // send one request and wait for it to be taken
  task automatic send_request(func_t f, logic [31:0] d, logic [31:0] nh,
                              logic [7:0] h, logic [16:0] r, logic [7:0] s,
                              logic [31:0] bw, logic [7:0] p, logic [31:0] now);
    in_valid           <= 1'b1;
    in_func            <= f;
    in_destination     <= d;
    in_next_hop        <= nh;
    in_hop_count       <= h;
    in_reliability     <= r;
    in_signal_strength <= s;
    in_bandwidth       <= bw;
    in_priority_req    <= p;
    in_now_ms          <= now;
    do @(posedge clk); while (!in_ready);
    // sender gaps in random bursts, none in the quiet phase
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // wait for every outstanding response, then let the walk finish before
  // a register write
  task automatic write_age_limit(logic [31:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed traffic over a small key set with random content
  task automatic random_request();
    logic [31:0] d, nh, now;
    logic [16:0] r;
    int          pick;
    pick = $urandom_range(0, 99);
    clock_ms += $urandom_range(0, 40000);
    now = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ms;
    d   = ($urandom_range(0, 9) == 0) ? $urandom() : dest_pool[$urandom_range(0, 15)];
    nh  = ($urandom_range(0, 9) == 0) ? $urandom() : hop_pool[$urandom_range(0, 5)];
    r   = ($urandom_range(0, 9) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    if (pick < 50)
      send_request(FN_UPDATE, d, nh, 8'($urandom()), r, 8'($urandom()), $urandom(),
                   8'($urandom()), now);
    else if (pick < 85)
      send_request(FN_LOOKUP, d, $urandom(), 8'($urandom()), 17'($urandom()),
                   8'($urandom()), $urandom(), 8'($urandom()), now);
    else if (pick < 93) begin
      send_request(FN_SWEEP, $urandom(), $urandom(), 8'($urandom()), 17'($urandom()),
                   8'($urandom()), $urandom(), 8'($urandom()), now);
      sweeps_sent++;
    end else
      send_request(FN_PURGE, $urandom(), nh, 8'($urandom()), 17'($urandom()),
                   8'($urandom()), $urandom(), 8'($urandom()), now);
  endtask

  // receiver: random stall bursts, one long hold, none in the quiet phase
  always @(posedge clk) begin
    if (!rst_n || quiet_phase) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (long_hold)
      out_ready <= 1'b0;
    else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else
      out_ready <= 1'b1;
  end

  // watchdog: cycles with no request or response moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("route_table_quality_replace regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FN_UPDATE;
    in_destination = '0;
    in_next_hop = '0;
    in_hop_count = '0;
    in_reliability = '0;
    in_signal_strength = '0;
    in_bandwidth = '0;
    in_priority_req = '0;
    in_now_ms = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet_phase = 1'b0;
    long_hold = 1'b0;
    stim_done = 1'b0;
    sweeps_sent = 0;
    clock_ms = 32'd1000;
    foreach (dest_pool[i]) dest_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom();
    foreach (hop_pool[i]) hop_pool[i] = (i == 0) ? 32'd0 : $urandom();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of fields, every operation and the special cases
    send_request(FN_LOOKUP, 32'd5, 32'd0, 8'd0, 17'd0, 8'd0, 32'd0, 8'd0, 32'd0);
    send_request(FN_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 17'h1FFFF, 8'h80,
                 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);       // reliability saturates
    send_request(FN_LOOKUP, 32'hFFFF_FFFF, 32'd0, 8'd0, 17'd0, 8'd0, 32'd0, 8'd0, 32'd7);
    send_request(FN_UPDATE, 32'd0, 32'd0, 8'd0, 17'd65536, 8'h7F, 32'd0, 8'd0, 32'd0);
    // same destination, better then worse score: replace, then keep
    send_request(FN_UPDATE, 32'hFFFF_FFFF, 32'd9, 8'd0, 17'd65536, 8'd3, 32'd1, 8'd2,
                 32'd100);
    send_request(FN_UPDATE, 32'hFFFF_FFFF, 32'd9, 8'd200, 17'd0, 8'd3, 32'd1, 8'd2,
                 32'd100);
    send_request(FN_LOOKUP, 32'd0, 32'd0, 8'd0, 17'd0, 8'd0, 32'd0, 8'd0, 32'd50);
    // one new destination per entry fills the table: the last ones find it full
    for (int i = 0; i < ROUTE_ENTRIES; i++)
      send_request(FN_UPDATE, 32'd1000 + i, 32'd77, 8'(i), 17'(i * 2000), 8'(i),
                   32'(i), 8'(i), 32'd200);
    // purge every route through one hop: a large removal count
    send_request(FN_PURGE, 32'd0, 32'd77, 8'd0, 17'd0, 8'd0, 32'd0, 8'd0, 32'd0);
    send_request(FN_SWEEP, 32'd0, 32'd0, 8'd0, 17'd0, 8'd0, 32'd0, 8'd0, 32'd400000);

    // receiver holds off long enough for the block to stall its input
    fork
      begin
        long_hold = 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
      repeat (6) random_request();
    join

    // random phases across several age limits, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_age_limit(32'd0);
        1: write_age_limit(32'hFFFF_FFFF);
        2: write_age_limit(32'd60000);
        3: write_age_limit($urandom());
        4: write_age_limit(32'd300000);
        default: write_age_limit(32'd120000);
      endcase
      if (ph == 5) quiet_phase = 1'b1;
      repeat (RANDOM_REQUESTS / 6) random_request();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run: drain outstanding responses, then the verdict
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d responses, %0d lookup hits, %0d random sweeps, six age limits",
             replies_seen, hits_seen, sweeps_sent);
    if (fail_count == 0 && pending == 0)
      $display("route_table_quality_replace regression: pass");
    else
      $display("route_table_quality_replace regression: fail");
    $finish;
  end
endmodule

@@ sim.f @@
design/rtq_pkg.sv
design/rtq_ram.sv
design/route_table_quality_replace.sv
tb/route_table_quality_replace_checker.sv
tb/route_table_quality_replace_test.sv
